### hdl/aph_pkg.sv
// Shared types, phase codes, status codes and constants of the address header parser.
package aph_pkg;

    localparam int MAX_ADDR_CHARS_DEF = 15;
    localparam int IN_DATA_W          = 8;
    localparam int OUT_DATA_W         = 16;

    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [2:0] TAG_LEN    = 3'd5;

    localparam logic [2:0] PH_PREFIX  = 3'd0;
    localparam logic [2:0] PH_SRC     = 3'd1;
    localparam logic [2:0] PH_TAG     = 3'd2;
    localparam logic [2:0] PH_DST     = 3'd3;
    localparam logic [2:0] PH_SPACE   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_SRC_CLOSE = 3'd1;
    localparam logic [2:0] ST_BAD_SRC_LEN = 3'd2;
    localparam logic [2:0] ST_NO_DST_TAG  = 3'd3;
    localparam logic [2:0] ST_NO_DST_CLOSE = 3'd4;
    localparam logic [2:0] ST_BAD_DST_LEN = 3'd5;
    localparam logic [2:0] ST_BAD_SRC_FMT = 3'd6;
    localparam logic [2:0] ST_BAD_DST_FMT = 3'd7;

    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [11:0] OCTET_MAX = 12'd255;
    localparam logic [2:0]  DOTS_REQ  = 3'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } aph_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        logic [2:0] frame_status;
    } aph_result_t;

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h5B;
            3'd1:    ch = 8'h44;
            3'd2:    ch = 8'h53;
            3'd3:    ch = 8'h54;
            3'd4:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hdl/address_header_parser_core.sv
// Top level of the address header parser: input register, parser, output register.
//
// channel   dir  tdata                          tuser            tlast
// s_        in   [7:0] char_byte                -                last_char
// m_        out  [7:0] payload_byte,            [0] payload_valid frame_done
//                [10:8] frame_status, rest zero
//
// One character is taken per cycle unless m_tready stalls; results pass both register stages.
// The parse state registers in the parser set the one-character-per-cycle loop.
// Characters that produce no result are consumed without an output transaction.
// rst_n clears all valid flags and returns the parser to the prefix phase.
// A stall on m_tready holds the output register and backs up through the input register.
module address_header_parser_core
    import aph_pkg::*;
#(
    parameter int MAX_ADDR_CHARS = MAX_ADDR_CHARS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] payload_byte, [10:8] frame_status
    output logic                  m_tuser,   // [0] payload_valid
    output logic                  m_tlast
);

    aph_item_t   in_item;
    aph_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        proc;
    logic        has_result;
    aph_result_t result;
    aph_result_t out_result;

    assign in_item.char_byte = s_tdata;
    assign in_item.last_char = s_tlast;

    aph_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign proc = item_valid && advance;

    aph_parser #(
        .MAX_ADDR_CHARS (MAX_ADDR_CHARS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc       (proc),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    aph_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (proc && has_result),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {5'b00000, out_result.frame_status, out_result.payload_byte};
    assign m_tuser = out_result.payload_valid;
    assign m_tlast = out_result.frame_done;

endmodule

### hdl/aph_in_reg.sv
// Input register stage holding one accepted character transaction.
module aph_in_reg
    import aph_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  aph_item_t in_item,
    input  logic      advance,
    output logic      item_valid,
    output aph_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    aph_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/aph_parser.sv
// Header parse state and per-character next-state and result logic.
module aph_parser
    import aph_pkg::*;
#(
    parameter int MAX_ADDR_CHARS = MAX_ADDR_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        proc,
    input  aph_item_t   item,
    output logic        has_result,
    output aph_result_t result
);

    localparam int LEN_W = $clog2(MAX_ADDR_CHARS + 2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ADDR_CHARS);

    logic [2:0]       phase_reg,        phase_next;
    logic [2:0]       prefix_count_reg, prefix_count_next;
    logic [LEN_W-1:0] addr_length_reg,  addr_length_next;
    logic [8:0]       octet_value_reg,  octet_value_next;
    logic [2:0]       dot_count_reg,    dot_count_next;
    logic             format_bad_reg,   format_bad_next;
    logic             src_format_bad_reg, src_format_bad_next;
    logic [2:0]       tag_progress_reg, tag_progress_next;
    logic [2:0]       error_code_reg,   error_code_next;

    logic [7:0]  c;
    logic        is_close;
    logic        is_digit;
    logic        is_dot;
    logic [11:0] octet_sum;
    logic        len_bad;
    logic        fmt_bad;
    logic        emit;
    logic [2:0]  status;

    assign c         = item.char_byte;
    assign is_close  = (c == CH_CLOSE);
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_dot    = (c == CH_DOT);
    assign octet_sum = {3'b000, octet_value_reg} * 12'd10 + {8'h00, c[3:0]};
    assign len_bad   = (addr_length_reg == '0) || (addr_length_reg > LEN_MAX);
    assign fmt_bad   = format_bad_reg || (dot_count_reg != DOTS_REQ);

    always_comb
    begin
        phase_next          = phase_reg;
        prefix_count_next   = prefix_count_reg;
        addr_length_next    = addr_length_reg;
        octet_value_next    = octet_value_reg;
        dot_count_next      = dot_count_reg;
        format_bad_next     = format_bad_reg;
        src_format_bad_next = src_format_bad_reg;
        tag_progress_next   = tag_progress_reg;
        error_code_next     = error_code_reg;
        emit                = 1'b0;
        status              = ST_OK;

        unique case (phase_reg)
            PH_PREFIX:
            begin
                if (is_close)
                begin
                    error_code_next = ST_BAD_SRC_LEN;
                    phase_next      = PH_ERROR;
                end
                else
                begin
                    prefix_count_next = prefix_count_reg + 3'd1;
                    if (prefix_count_next >= PREFIX_LEN)
                    begin
                        phase_next       = PH_SRC;
                        addr_length_next = '0;
                        octet_value_next = '0;
                        dot_count_next   = '0;
                        format_bad_next  = 1'b0;
                    end
                end
            end
            PH_TAG:
            begin
                if (c == tag_char(tag_progress_reg))
                begin
                    tag_progress_next = tag_progress_reg + 3'd1;
                    if (tag_progress_next >= TAG_LEN)
                    begin
                        phase_next       = PH_DST;
                        addr_length_next = '0;
                        octet_value_next = '0;
                        dot_count_next   = '0;
                        format_bad_next  = 1'b0;
                    end
                end
                else
                begin
                    tag_progress_next = (c == CH_OPEN) ? 3'd1 : 3'd0;
                end
            end
            PH_SRC, PH_DST:
            begin
                if (is_close)
                begin
                    if (phase_reg == PH_SRC)
                    begin
                        if (len_bad)
                        begin
                            error_code_next = ST_BAD_SRC_LEN;
                            phase_next      = PH_ERROR;
                        end
                        else
                        begin
                            src_format_bad_next = fmt_bad;
                            tag_progress_next   = 3'd0;
                            phase_next          = PH_TAG;
                        end
                    end
                    else
                    begin
                        priority if (len_bad)
                        begin
                            error_code_next = ST_BAD_DST_LEN;
                            phase_next      = PH_ERROR;
                        end
                        else if (src_format_bad_reg)
                        begin
                            error_code_next = ST_BAD_SRC_FMT;
                            phase_next      = PH_ERROR;
                        end
                        else if (fmt_bad)
                        begin
                            error_code_next = ST_BAD_DST_FMT;
                            phase_next      = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_SPACE;
                        end
                    end
                end
                else
                begin
                    if (addr_length_reg <= LEN_MAX)
                    begin
                        addr_length_next = addr_length_reg + LEN_W'(1);
                    end
                    if (!format_bad_reg)
                    begin
                        priority if (is_digit)
                        begin
                            octet_value_next = octet_sum[8:0];
                            if (octet_sum > OCTET_MAX)
                            begin
                                format_bad_next = 1'b1;
                            end
                        end
                        else if (is_dot)
                        begin
                            octet_value_next = '0;
                            dot_count_next   = dot_count_reg + 3'd1;
                            if (dot_count_next > DOTS_REQ)
                            begin
                                format_bad_next = 1'b1;
                            end
                        end
                        else
                        begin
                            format_bad_next = 1'b1;
                        end
                    end
                end
            end
            PH_SPACE:
            begin
                phase_next = PH_PAYLOAD;
                emit       = (c != CH_SPACE);
            end
            PH_PAYLOAD:
            begin
                emit = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (item.last_char)
        begin
            unique case (phase_next)
                PH_PREFIX, PH_SRC:   status = ST_NO_SRC_CLOSE;
                PH_TAG:              status = ST_NO_DST_TAG;
                PH_DST:              status = ST_NO_DST_CLOSE;
                PH_SPACE, PH_PAYLOAD: status = ST_OK;
                default:             status = error_code_next;
            endcase
            phase_next          = PH_PREFIX;
            prefix_count_next   = '0;
            addr_length_next    = '0;
            octet_value_next    = '0;
            dot_count_next      = '0;
            format_bad_next     = 1'b0;
            src_format_bad_next = 1'b0;
            tag_progress_next   = '0;
            error_code_next     = '0;
        end
    end

    assign has_result           = emit || item.last_char;
    assign result.payload_byte  = emit ? c : 8'h00;
    assign result.payload_valid = emit;
    assign result.frame_done    = item.last_char;
    assign result.frame_status  = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_PREFIX;
            prefix_count_reg   <= '0;
            addr_length_reg    <= '0;
            octet_value_reg    <= '0;
            dot_count_reg      <= '0;
            format_bad_reg     <= 1'b0;
            src_format_bad_reg <= 1'b0;
            tag_progress_reg   <= '0;
            error_code_reg     <= '0;
        end
        else if (proc)
        begin
            phase_reg          <= phase_next;
            prefix_count_reg   <= prefix_count_next;
            addr_length_reg    <= addr_length_next;
            octet_value_reg    <= octet_value_next;
            dot_count_reg      <= dot_count_next;
            format_bad_reg     <= format_bad_next;
            src_format_bad_reg <= src_format_bad_next;
            tag_progress_reg   <= tag_progress_next;
            error_code_reg     <= error_code_next;
        end
    end

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && item.last_char |=> phase_reg == PH_PREFIX && error_code_reg == '0)
        else $error("parse state not cleared after frame end");

    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        proc && has_result && result.payload_valid |->
            phase_reg == PH_SPACE || phase_reg == PH_PAYLOAD)
        else $error("payload emitted before header passed");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> error_code_reg != ST_OK)
        else $error("error phase without error code");

    a_dot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dot_count_reg <= 3'd4)
        else $error("dot count beyond saturation");

endmodule

### hdl/aph_out_reg.sv
// Output register stage holding one result transaction for the downstream side.
module aph_out_reg
    import aph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  aph_result_t result,
    output logic        advance,
    output logic        out_valid,
    input  logic        out_ready,
    output aph_result_t out_result
);

    logic        valid_reg;
    logic        valid_next;
    aph_result_t result_reg;

    assign advance    = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
